// ----- hw/rtl/battrk_pkg.sv -----
// Package for the battery voltage tracker: widths, fixed-point constants,
// register indexes, event codes and the divider status type.
// Used by battrk_mul, battrk_div and battery_voltage_tracker_autocal.
`default_nettype none

package battrk_pkg;

  // payload widths
  localparam int unsigned SUM_W    = 15;
  localparam int unsigned GAIN_W   = 18;
  localparam int unsigned ALPHA_W  = 17;
  localparam int unsigned CONF_W   = 8;
  localparam int unsigned FCMV_W   = 13;
  localparam int unsigned FACT_W   = 17;
  localparam int unsigned V_W      = 22;
  localparam int unsigned PCT_W    = 15;
  localparam int unsigned EV_W     = 2;
  localparam int unsigned CFG_IW   = 3;
  localparam int unsigned CFG_DW   = 18;
  localparam int unsigned IN_DW    = 24;
  localparam int unsigned OUT_DW   = 56;

  // shared multiplier operand and product widths
  localparam int unsigned MUL_AW   = 33;
  localparam int unsigned MUL_BW   = 22;
  localparam int unsigned MUL_PW   = MUL_AW + MUL_BW;

  // iterative divider: dividend, divisor, quotient, step counter
  localparam int unsigned DVD_W    = 39;
  localparam int unsigned DVS_W    = 22;
  localparam int unsigned QUO_W    = 23;
  localparam int unsigned CNT_W    = 5;

  // averaging over 8 samples plus Q16 gain and Q16 factor
  localparam int unsigned OVS_LOG2 = 3;
  localparam int unsigned INST_SH  = 32 - 8 + OVS_LOG2;

  localparam logic [V_W-1:0]      V_MAX      = 22'd4194303;
  localparam logic [V_W-1:0]      MIN_CAL_MV = 22'd128000;
  localparam logic [V_W-1:0]      SEG0_MV    = 22'd844800;
  localparam logic [V_W-1:0]      SEG1_MV    = 22'd921600;
  localparam logic [PCT_W-1:0]    PCT10      = 15'd2560;
  localparam logic [PCT_W-1:0]    PCT100     = 15'd25600;
  localparam logic [ALPHA_W-1:0]  Q16_ONE    = 17'd65536;
  localparam logic [CONF_W-1:0]   RUN_MAX    = 8'd255;

  // percent segment reciprocals: y/30 and w/5, exact over their input ranges
  localparam logic [MUL_AW-1:0]   SEG_LO_RCP = 33'd139811;
  localparam logic [MUL_AW-1:0]   SEG_HI_RCP = 33'd3355444;
  localparam int unsigned         SEG_LO_SH  = 22;
  localparam int unsigned         SEG_HI_SH  = 24;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] REG_GAIN   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ALPHA  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_CONF   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_FCMV   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_FMIN   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_FMAX   = 3'd5;
  localparam logic [CFG_IW-1:0] REG_FSTART = 3'd6;

  // register reset values
  localparam logic [GAIN_W-1:0]  GAIN_RST   = 18'd146684;
  localparam logic [ALPHA_W-1:0] ALPHA_RST  = 17'd19661;
  localparam logic [CONF_W-1:0]  CONF_RST   = 8'd3;
  localparam logic [FCMV_W-1:0]  FCMV_RST   = 13'd4200;
  localparam logic [FACT_W-1:0]  FMIN_RST   = 17'd55706;
  localparam logic [FACT_W-1:0]  FMAX_RST   = 17'd75366;
  localparam logic [FACT_W-1:0]  FSTART_RST = 17'd65536;

  // calibration event codes
  localparam logic [EV_W-1:0] EV_NONE     = 2'd0;
  localparam logic [EV_W-1:0] EV_APPLIED  = 2'd1;
  localparam logic [EV_W-1:0] EV_REJECTED = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/battrk_mul.sv -----
// Shared registered multiplier of the battery voltage tracker.
// Depends on battrk_pkg for operand widths.
`default_nettype none

module battrk_mul (
  input  wire logic                        clk_i,
  input  wire logic [battrk_pkg::MUL_AW-1:0] a_i,
  input  wire logic [battrk_pkg::MUL_BW-1:0] b_i,
  output logic      [battrk_pkg::MUL_PW-1:0] prod_o
);
  import battrk_pkg::*;

  logic [MUL_PW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= MUL_PW'(a_i) * MUL_PW'(b_i);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ----- hw/rtl/battrk_div.sv -----
// Restoring divider of the battery voltage tracker, one quotient bit a cycle.
// Depends on battrk_pkg; the dividend's upper part must stay below the divisor.
`default_nettype none

module battrk_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [battrk_pkg::DVD_W-1:0]  dividend_i,
  input  wire logic [battrk_pkg::DVS_W-1:0]  divisor_i,
  output battrk_pkg::div_stat_t              stat_o,
  output logic      [battrk_pkg::QUO_W-1:0]  quo_o
);
  import battrk_pkg::*;

  logic [DVS_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0] low_q, low_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  assign trial = {rem_q, low_q[QUO_W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    low_d  = low_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = DVS_W'(dividend_i[DVD_W-1:QUO_W]);
      low_d  = dividend_i[QUO_W-1:0];
      dvs_d  = divisor_i;
      quo_d  = '0;
      cnt_d  = CNT_W'(QUO_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // keep the partial remainder below the divisor
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[DVS_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DVS_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], 1'b0};
      end
      low_d = {low_q[QUO_W-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

endmodule

`default_nettype wire

// ----- hw/rtl/battery_voltage_tracker_autocal.sv -----
// Battery voltage tracker with exponential smoothing and end-of-charge
// self-calibration. Sequencer and state; uses battrk_pkg, battrk_mul, battrk_div.
//
// Usage:
//   s_axis carries one reading: tdata = {usb_present, charging, sample_sum}.
//   m_axis returns one result per reading:
//   tdata = {factor_q16, cal_event, percent_q8, voltage_mv_q8}.
//   cfg_* writes register cfg_index_i with cfg_data_i; it is
//   always ready. Write it only while no reading is in flight. Writing the
//   start factor also loads the factor in use.
// Sequence: a result is offered after the gain and factor multiplies, the
//   average update (skipped for the first reading), the charge run update and
//   the percent multiply (skipped below 3300 mV); a calibration attempt at
//   charge end adds the candidate multiply and the bit-serial divider. The next
//   reading is accepted only after the previous one has left the sequencer.
// s_axis_tready is high only while the sequencer is idle. A finished result
//   sits in the output register; the next reading is accepted meanwhile, and
//   its result waits until the receiver has taken the previous one.
// Reset loads the register defaults, clears the average and the charge run,
//   and empties the output register.
`default_nettype none

module battery_voltage_tracker_autocal (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [14:0] sample_sum, [15] charging, [16] usb_present, [23:17] zero
  input  wire logic [battrk_pkg::IN_DW-1:0]     s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [21:0] voltage_mv_q8, [36:22] percent_q8, [38:37] cal_event,
  // [55:39] factor_q16
  output logic      [battrk_pkg::OUT_DW-1:0]    m_axis_tdata,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [battrk_pkg::CFG_IW-1:0]    cfg_index_i,
  input  wire logic [battrk_pkg::CFG_DW-1:0]    cfg_data_i
);
  import battrk_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_M_GAIN = 4'd1;
  localparam logic [3:0] S_M_CAL  = 4'd2;
  localparam logic [3:0] S_INST   = 4'd3;
  localparam logic [3:0] S_M_NEW  = 4'd4;
  localparam logic [3:0] S_M_OLD  = 4'd5;
  localparam logic [3:0] S_EMA    = 4'd6;
  localparam logic [3:0] S_RUN    = 4'd7;
  localparam logic [3:0] S_CAND   = 4'd8;
  localparam logic [3:0] S_DIVC   = 4'd9;
  localparam logic [3:0] S_PCT    = 4'd10;
  localparam logic [3:0] S_PCT_M  = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  // configuration registers
  logic [GAIN_W-1:0]  gain_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic [CONF_W-1:0]  conf_q;
  logic [FCMV_W-1:0]  fcmv_q;
  logic [FACT_W-1:0]  fmin_q;
  logic [FACT_W-1:0]  fmax_q;
  logic [FACT_W-1:0]  fstart_q;

  // tracker state
  logic [3:0]        state_q, state_d;
  logic [V_W-1:0]    smooth_q, smooth_d;
  logic              valid_q, valid_d;
  logic [FACT_W-1:0] cal_q, cal_d;
  logic              was_chg_q, was_chg_d;
  logic [CONF_W-1:0] run_q, run_d;

  // per-reading working registers
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              chg_q, chg_d;
  logic              usb_q, usb_d;
  logic [V_W-1:0]    inst_q, inst_d;
  logic [38:0]       acc_q, acc_d;
  logic [EV_W-1:0]   ev_q, ev_d;
  logic [PCT_W-1:0]  pct_q, pct_d;
  logic              seg_hi_q, seg_hi_d;

  // output register
  logic              m_valid_q, m_valid_d;
  logic [OUT_DW-1:0] m_data_q, m_data_d;

  // shared units
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] prod;
  logic              div_start;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  div_stat_t         div_stat;
  logic [QUO_W-1:0]  quo;

  logic              in_xfer;
  logic              cfg_wr;
  logic              adopt;
  logic [ALPHA_W-1:0] a_eff;
  logic [ALPHA_W-1:0] a_rest;
  logic [50:0]       inst_rnd;
  logic [23:0]       inst_full;
  logic [39:0]       ema_sum;
  logic [23:0]       ema_full;
  logic [CONF_W-1:0] run_new;
  logic              cal_go;
  logic [V_W-1:0]    seg_lo_y;
  logic [V_W-1:0]    seg_hi_x;
  logic [23:0]       seg_hi_z;
  logic [QUO_W:0]    pct_hi;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign cfg_wr        = cfg_valid_i && cfg_ready_o;

  // alpha above one acts as one
  assign a_eff  = alpha_q[ALPHA_W-1] ? Q16_ONE : alpha_q;
  assign a_rest = Q16_ONE - a_eff;

  assign inst_rnd  = {1'b0, prod[49:0]} + (51'd1 << (INST_SH - 1));
  assign inst_full = inst_rnd[INST_SH+23:INST_SH];
  assign ema_sum   = {1'b0, acc_q} + {1'b0, prod[38:0]} + 40'd32768;
  assign ema_full  = ema_sum[39:16];

  assign run_new = (chg_q && run_q != RUN_MAX) ? run_q + CONF_W'(1) : run_q;
  assign cal_go  = was_chg_q && !chg_q && usb_q && (run_new >= conf_q) &&
                   (smooth_q > MIN_CAL_MV);

  assign seg_lo_y = smooth_q - SEG0_MV + V_W'(15);
  assign seg_hi_x = smooth_q - SEG1_MV;
  // (15x + 50) / 100 equals ((3x + 10) / 4) / 5
  assign seg_hi_z = ({2'b0, seg_hi_x} << 1) + {2'b0, seg_hi_x} + 24'd10;
  assign pct_hi   = (QUO_W+1)'(PCT10) + {1'b0, prod[SEG_HI_SH +: QUO_W]};

  assign adopt = (state_q == S_DIVC) && div_stat.done &&
                 (quo >= QUO_W'(fmin_q)) && (quo <= QUO_W'(fmax_q));

  battrk_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  battrk_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .stat_o     (div_stat),
    .quo_o      (quo)
  );

  always_comb begin
    state_d   = state_q;
    smooth_d  = smooth_q;
    valid_d   = valid_q;
    cal_d     = cal_q;
    was_chg_d = was_chg_q;
    run_d     = run_q;
    sum_d     = sum_q;
    chg_d     = chg_q;
    usb_d     = usb_q;
    inst_d    = inst_q;
    acc_d     = acc_q;
    ev_d      = ev_q;
    pct_d     = pct_q;
    seg_hi_d  = seg_hi_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;

    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          sum_d   = s_axis_tdata[SUM_W-1:0];
          chg_d   = s_axis_tdata[SUM_W];
          usb_d   = s_axis_tdata[SUM_W+1];
          ev_d    = EV_NONE;
          state_d = S_M_GAIN;
        end
      end
      S_M_GAIN: begin
        mul_a   = MUL_AW'(sum_q);
        mul_b   = MUL_BW'(gain_q);
        state_d = S_M_CAL;
      end
      S_M_CAL: begin
        mul_a   = prod[MUL_AW-1:0];
        mul_b   = MUL_BW'(cal_q);
        state_d = S_INST;
      end
      S_INST: begin
        inst_d = (|inst_full[23:V_W]) ? V_MAX : inst_full[V_W-1:0];
        if (!valid_q) begin
          // first reading seeds the average
          smooth_d = (|inst_full[23:V_W]) ? V_MAX : inst_full[V_W-1:0];
          valid_d  = 1'b1;
          state_d  = S_RUN;
        end else begin
          state_d = S_M_NEW;
        end
      end
      S_M_NEW: begin
        mul_a   = MUL_AW'(a_eff);
        mul_b   = inst_q;
        state_d = S_M_OLD;
      end
      S_M_OLD: begin
        mul_a   = MUL_AW'(a_rest);
        mul_b   = smooth_q;
        acc_d   = prod[38:0];
        state_d = S_EMA;
      end
      S_EMA: begin
        smooth_d = (|ema_full[23:V_W]) ? V_MAX : ema_full[V_W-1:0];
        state_d  = S_RUN;
      end
      S_RUN: begin
        run_d     = chg_q ? run_new : '0;
        was_chg_d = chg_q;
        if (cal_go) begin
          mul_a   = MUL_AW'(cal_q);
          mul_b   = MUL_BW'(fcmv_q);
          state_d = S_CAND;
        end else begin
          state_d = S_PCT;
        end
      end
      S_CAND: begin
        // candidate = round(factor * full_mv * 256 / smoothed)
        div_start = 1'b1;
        div_dvd   = {1'b0, prod[29:0], 8'b0} + DVD_W'(smooth_q[V_W-1:1]);
        div_dvs   = smooth_q;
        state_d   = S_DIVC;
      end
      S_DIVC: begin
        if (div_stat.done) begin
          if (adopt) begin
            cal_d    = quo[FACT_W-1:0];
            smooth_d = {1'b0, fcmv_q, 8'b0};
            ev_d     = EV_APPLIED;
          end else begin
            ev_d = EV_REJECTED;
          end
          state_d = S_PCT;
        end
      end
      S_PCT: begin
        if (smooth_q < SEG0_MV) begin
          pct_d   = '0;
          state_d = S_OUT;
        end else begin
          // divide through a reciprocal multiply on the shared multiplier
          if (smooth_q < SEG1_MV) begin
            mul_a    = SEG_LO_RCP;
            mul_b    = seg_lo_y;
            seg_hi_d = 1'b0;
          end else begin
            mul_a    = SEG_HI_RCP;
            mul_b    = seg_hi_z[23:2];
            seg_hi_d = 1'b1;
          end
          state_d = S_PCT_M;
        end
      end
      S_PCT_M: begin
        if (!seg_hi_q) begin
          pct_d = prod[SEG_LO_SH +: PCT_W];
        end else if (pct_hi > (QUO_W+1)'(PCT100)) begin
          pct_d = PCT100;
        end else begin
          pct_d = pct_hi[PCT_W-1:0];
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {cal_q, ev_q, pct_q, smooth_q};
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_wr && cfg_index_i == REG_FSTART) begin
      cal_d = cfg_data_i[FACT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      smooth_q  <= '0;
      valid_q   <= 1'b0;
      cal_q     <= FSTART_RST;
      was_chg_q <= 1'b0;
      run_q     <= '0;
      m_valid_q <= 1'b0;
      gain_q    <= GAIN_RST;
      alpha_q   <= ALPHA_RST;
      conf_q    <= CONF_RST;
      fcmv_q    <= FCMV_RST;
      fmin_q    <= FMIN_RST;
      fmax_q    <= FMAX_RST;
      fstart_q  <= FSTART_RST;
    end else begin
      state_q   <= state_d;
      smooth_q  <= smooth_d;
      valid_q   <= valid_d;
      cal_q     <= cal_d;
      was_chg_q <= was_chg_d;
      run_q     <= run_d;
      m_valid_q <= m_valid_d;
      if (cfg_wr) begin
        case (cfg_index_i)
          REG_GAIN:   gain_q   <= cfg_data_i[GAIN_W-1:0];
          REG_ALPHA:  alpha_q  <= cfg_data_i[ALPHA_W-1:0];
          REG_CONF:   conf_q   <= cfg_data_i[CONF_W-1:0];
          REG_FCMV:   fcmv_q   <= cfg_data_i[FCMV_W-1:0];
          REG_FMIN:   fmin_q   <= cfg_data_i[FACT_W-1:0];
          REG_FMAX:   fmax_q   <= cfg_data_i[FACT_W-1:0];
          REG_FSTART: fstart_q <= cfg_data_i[FACT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q    <= sum_d;
    chg_q    <= chg_d;
    usb_q    <= usb_d;
    inst_q   <= inst_d;
    acc_q    <= acc_d;
    ev_q     <= ev_d;
    pct_q    <= pct_d;
    seg_hi_q <= seg_hi_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTHESIS
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_factor_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(cfg_wr && cfg_index_i == REG_FSTART) && !adopt) |=> $stable(cal_q))
    else $error("factor changed without write or calibration");

  a_out_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && m_valid_q && !m_axis_tready) |=> state_q == S_OUT)
    else $error("result overwrote a pending transfer");

  a_fstart_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && cfg_index_i == REG_FSTART) |=> cal_q == fstart_q)
    else $error("start factor not loaded into factor in use");
`endif

endmodule

`default_nettype wire

// ----- tb/battery_voltage_tracker_autocal_tb.sv -----
// Testbench for battery_voltage_tracker_autocal: readings are streamed in, results are
// predicted by a bit-exact tracker model and compared field by field.
// Depends on battrk_pkg and the battery_voltage_tracker_autocal RTL.
`timescale 1ns / 100ps

module battery_voltage_tracker_autocal_tb;
  import battrk_pkg::*;

  typedef struct packed {
    logic [6:0]       pad;
    logic             usb;
    logic             chg;
    logic [SUM_W-1:0] sum;
  } reading_t;

  typedef struct packed {
    logic [FACT_W-1:0] factor;
    logic [EV_W-1:0]   ev;
    logic [PCT_W-1:0]  pct;
    logic [V_W-1:0]    mv;
  } tracker_result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  reading_t             s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_DW-1:0]    m_axis_tdata;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IW-1:0]    cfg_index_i   = '0;
  logic [CFG_DW-1:0]    cfg_data_i    = '0;

  battery_voltage_tracker_autocal dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // tracker model: configuration
  logic [GAIN_W-1:0]  gain_q16     = GAIN_RST;
  logic [ALPHA_W-1:0] alpha_q16    = ALPHA_RST;
  logic [CONF_W-1:0]  confirm_need = CONF_RST;
  logic [FCMV_W-1:0]  full_mv      = FCMV_RST;
  logic [FACT_W-1:0]  fmin_q16     = FMIN_RST;
  logic [FACT_W-1:0]  fmax_q16     = FMAX_RST;
  logic [FACT_W-1:0]  fstart_q16   = FSTART_RST;

  // tracker model: state
  logic [V_W-1:0]     smooth_mv      = '0;
  logic               smooth_seeded  = 1'b0;
  logic [FACT_W-1:0]  cal_factor_q16 = FSTART_RST;
  logic               prev_charging  = 1'b0;
  logic [CONF_W-1:0]  charge_run     = '0;

  reading_t           pending_readings[$];
  tracker_result_t    expected_results[$];

  int  sender_idle_pct    = 0;
  int  receiver_stall_pct = 0;
  logic pressure_go       = 1'b0;
  logic hold_off          = 1'b0;
  int  mismatches         = 0;
  int  results_seen       = 0;

  function automatic logic [PCT_W-1:0] percent_for(input logic [V_W-1:0] v);
    logic [63:0] p;
    if (v < SEG0_MV) return '0;
    if (v < SEG1_MV) return PCT_W'((64'(v) - SEG0_MV + 15) / 30);
    p = PCT10 + ((64'(v) - SEG1_MV) * 15 + 50) / 100;
    return (p > PCT100) ? PCT100 : p[PCT_W-1:0];
  endfunction

  task automatic predict_reading(input reading_t rd);
    logic [63:0]     inst;
    logic [63:0]     alpha_eff;
    logic [63:0]     acc;
    logic [63:0]     num;
    logic [63:0]     cand;
    tracker_result_t res;
    res.ev = EV_NONE;
    inst = (64'(rd.sum) * gain_q16 * cal_factor_q16 + (64'd1 << (INST_SH - 1))) >> INST_SH;
    if (inst > V_MAX) inst = V_MAX;
    if (!smooth_seeded) begin
      smooth_mv = inst[V_W-1:0];
      smooth_seeded = 1'b1;
    end else begin
      alpha_eff = (alpha_q16 > Q16_ONE) ? 64'(Q16_ONE) : 64'(alpha_q16);
      acc = (alpha_eff * inst + (64'd65536 - alpha_eff) * smooth_mv + 64'd32768) >> 16;
      smooth_mv = (acc > V_MAX) ? V_MAX : acc[V_W-1:0];
    end
    if (rd.chg && charge_run != RUN_MAX) charge_run = charge_run + 1'b1;
    if (prev_charging && !rd.chg && rd.usb && charge_run >= confirm_need &&
        smooth_mv > MIN_CAL_MV) begin
      num  = 64'(cal_factor_q16) * full_mv * 256;
      cand = (num + smooth_mv / 2) / smooth_mv;
      // limits compare at full width, so inverted limits reject everything
      if (cand >= fmin_q16 && cand <= fmax_q16) begin
        cal_factor_q16 = cand[FACT_W-1:0];
        smooth_mv = V_W'({full_mv, 8'd0});
        res.ev = EV_APPLIED;
      end else begin
        res.ev = EV_REJECTED;
      end
    end
    if (!rd.chg) charge_run = '0;
    prev_charging = rd.chg;
    res.mv = smooth_mv;
    res.pct = percent_for(smooth_mv);
    res.factor = cal_factor_q16;
    expected_results.push_back(res);
  endtask

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    $display("%0t ns: result %0d %s: got %0d, expected %0d", $time, results_seen, what,
             got, want);
    mismatches++;
  endtask

  // input driver: hold an offered reading until its transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_readings.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_readings.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !hold_off && ($urandom_range(99) >= receiver_stall_pct);
  end

  // long hold-off on the result side so the block backs up into its input
  initial begin
    wait (pressure_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (600) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin : monitor
    tracker_result_t got;
    tracker_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_results.size() == 0) begin
          flag_mismatch("arrived with none expected", m_axis_tdata, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.mv !== want.mv) flag_mismatch("voltage_mv_q8", got.mv, want.mv);
          if (got.pct !== want.pct) flag_mismatch("percent_q8", got.pct, want.pct);
          if (got.ev !== want.ev) flag_mismatch("cal_event", got.ev, want.ev);
          if (got.factor !== want.factor) flag_mismatch("factor_q16", got.factor, want.factor);
        end
        results_seen++;
      end
      if (s_axis_tvalid && s_axis_tready) predict_reading(s_axis_tdata);
    end
  end

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_GAIN:   gain_q16 = value[GAIN_W-1:0];
      REG_ALPHA:  alpha_q16 = value[ALPHA_W-1:0];
      REG_CONF:   confirm_need = value[CONF_W-1:0];
      REG_FCMV:   full_mv = value[FCMV_W-1:0];
      REG_FMIN:   fmin_q16 = value[FACT_W-1:0];
      REG_FMAX:   fmax_q16 = value[FACT_W-1:0];
      REG_FSTART: begin
        fstart_q16 = value[FACT_W-1:0];
        cal_factor_q16 = value[FACT_W-1:0];
      end
      default: ;
    endcase
  endtask

  task automatic write_all(input int gain, input int alpha, input int conf, input int fcmv,
                           input int fmin, input int fmax, input int fstart);
    write_reg(REG_GAIN, CFG_DW'(gain));
    write_reg(REG_ALPHA, CFG_DW'(alpha));
    write_reg(REG_CONF, CFG_DW'(conf));
    write_reg(REG_FCMV, CFG_DW'(fcmv));
    write_reg(REG_FMIN, CFG_DW'(fmin));
    write_reg(REG_FMAX, CFG_DW'(fmax));
    write_reg(REG_FSTART, CFG_DW'(fstart));
  endtask

  task automatic write_random_config();
    write_all($urandom_range(130000, 160000), $urandom_range(0, 65536), $urandom_range(0, 5),
              $urandom_range(3600, 4400), $urandom_range(60000, 65000),
              $urandom_range(68000, 75000), $urandom_range(60000, 72000));
  endtask

  task automatic queue_reading(input int s, input bit chg, input bit usb);
    reading_t r;
    r = '0;
    r.sum = (s < 0) ? '0 : (s > 32767) ? 15'h7fff : SUM_W'(s);
    r.chg = chg;
    r.usb = usb;
    pending_readings.push_back(r);
  endtask

  task automatic queue_repeat(input int s, input bit chg, input bit usb, input int n);
    repeat (n) queue_reading(s, chg, usb);
  endtask

  // ADC sum that lands near a given voltage with the current gain and factor
  function automatic int sum_for_mv(input int mv);
    longint unsigned den;
    longint unsigned num;
    den = 64'(gain_q16) * cal_factor_q16;
    if (den == 0 || mv <= 0) return $urandom_range(32767);
    num = mv;
    num = (num << 35) / den;
    return (num > 32767) ? 32767 : int'(num);
  endfunction

  function automatic int wobble(input int s);
    return s + int'($urandom_range(0, 60)) - 30;
  endfunction

  // discharge lead-in, a charging run, then the end-of-charge reading
  task automatic queue_charge_cycle(input int n_chg, input bit usb_end);
    int base;
    base = sum_for_mv(int'(full_mv) + int'($urandom_range(0, 200)) - 120);
    repeat ($urandom_range(0, 2)) queue_reading(wobble(base), 1'b0, 1'($urandom_range(1)));
    repeat (n_chg) queue_reading(wobble(base), 1'b1, 1'b1);
    queue_reading(wobble(base), 1'b0, usb_end);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_readings.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
  endtask

  task automatic run_random_phase(input int n);
    int pick;
    while (pending_readings.size() < n) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        queue_charge_cycle($urandom_range(0, (confirm_need > 6) ? 8 : confirm_need + 2),
                           $urandom_range(99) < 85);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4))
          queue_reading(sum_for_mv($urandom_range(3000, 4400)), 1'b0,
                        1'($urandom_range(1)));
      end else begin
        queue_reading($urandom_range(32767), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset defaults: zero seed, low-voltage charge end, missing usb, short run,
    // then an accepted and a rejected calibration
    queue_repeat(0, 1'b0, 1'b0, 1);
    queue_repeat(0, 1'b1, 1'b1, 3);
    queue_repeat(0, 1'b0, 1'b1, 1);
    queue_repeat(32767, 1'b0, 1'b0, 1);
    queue_repeat(14833, 1'b1, 1'b1, 4);
    queue_repeat(14833, 1'b0, 1'b0, 1);
    queue_repeat(14833, 1'b1, 1'b1, 2);
    queue_repeat(14833, 1'b0, 1'b1, 1);
    queue_repeat(14833, 1'b1, 1'b1, 3);
    queue_repeat(14833, 1'b0, 1'b1, 1);
    queue_repeat(10000, 1'b0, 1'b0, 2);
    queue_repeat(10000, 1'b1, 1'b1, 3);
    queue_repeat(10000, 1'b0, 1'b1, 1);
    wait_idle();

    // zero confirm, inverted limits, the rest at top: alpha above one, saturation
    write_all(262143, 131071, 0, 8191, 131071, 0, 131071);
    queue_repeat(0, 1'b0, 1'b0, 1);
    queue_repeat(32767, 1'b0, 1'b0, 1);
    queue_repeat(32767, 1'b1, 1'b1, 1);
    queue_repeat(32767, 1'b0, 1'b1, 1);
    wait_idle();

    // confirm 1, top upper limit, rest zero: average frozen, zero factor accepted
    write_all(0, 0, 1, 0, 0, 131071, 0);
    queue_repeat(100, 1'b1, 1'b1, 1);
    queue_repeat(100, 1'b0, 1'b1, 1);
    queue_repeat(32767, 1'b0, 1'b0, 1);
    wait_idle();

    write_all(GAIN_RST, ALPHA_RST, CONF_RST, FCMV_RST, FMIN_RST, FMAX_RST, FSTART_RST);
    @(negedge clk_i);
    pressure_go = 1'b1;
    run_random_phase(100);

    write_random_config();
    @(negedge clk_i);
    sender_idle_pct = 69;
    run_random_phase(100);

    write_random_config();
    @(negedge clk_i);
    sender_idle_pct = 0;
    receiver_stall_pct = 69;
    run_random_phase(100);

    // charge run long enough to saturate the counter and meet the top confirm count
    write_all(GAIN_RST, ALPHA_RST, 255, FCMV_RST, FMIN_RST, FMAX_RST, FSTART_RST);
    @(negedge clk_i);
    sender_idle_pct = 27;
    receiver_stall_pct = 27;
    queue_charge_cycle(258, 1'b1);
    run_random_phase(310);

    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- battery_voltage_tracker_autocal.f -----
hw/rtl/battrk_pkg.sv
hw/rtl/battrk_mul.sv
hw/rtl/battrk_div.sv
hw/rtl/battery_voltage_tracker_autocal.sv
tb/battery_voltage_tracker_autocal_tb.sv
